// ===== design/qdf_pkg.sv =====
`timescale 1ns / 1ps
package qdf_pkg;

  localparam int FIFO_DEPTH = 16;
  localparam int PTR_W      = $clog2(FIFO_DEPTH);
  localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

  localparam int PORT_W     = 8;
  localparam int BIT_SEL_W  = $clog2(PORT_W);
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = BIT_SEL_W;

  localparam logic [CFG_IDX_W-1:0] CFG_CLOCK_BIT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DATA_BIT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ENABLE    = 2'd2;

  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_READ   = 1'b1;

  // stored event encoding
  localparam logic EVT_CW  = 1'b0;
  localparam logic EVT_ACW = 1'b1;

  typedef enum logic [1:0] {
    DIR_NONE = 2'd0,
    DIR_CW   = 2'd1,
    DIR_ACW  = 2'd2
  } dir_t;

  typedef logic [1:0] phase_t;

  typedef struct packed {
    logic valid;
    logic acw;
  } qdf_evt_t;

  typedef struct packed {
    logic push;
    logic push_acw;
    logic pop;
  } qdf_fifo_req_t;

endpackage

// ===== design/qdf_in_if.sv =====
`timescale 1ns / 1ps
interface qdf_in_if;
  logic                         valid;
  logic                         ready;
  logic                         operation;
  logic [qdf_pkg::PORT_W-1:0]   port_value;

  modport source (output valid, output operation, output port_value, input ready);
  modport sink   (input valid, input operation, input port_value, output ready);
endinterface

// ===== design/qdf_out_if.sv =====
`timescale 1ns / 1ps
interface qdf_out_if;
  logic                        valid;
  logic                        ready;
  qdf_pkg::dir_t               direction;
  logic [qdf_pkg::CNT_W-1:0]   pending;

  modport source (output valid, output direction, output pending, input ready);
  modport sink   (input valid, input direction, input pending, output ready);
endinterface

// ===== design/qdf_decode.sv =====
`timescale 1ns / 1ps
module qdf_decode (
  input  logic [qdf_pkg::PORT_W-1:0]    port_value,
  input  logic [qdf_pkg::BIT_SEL_W-1:0] clock_bit,
  input  logic [qdf_pkg::BIT_SEL_W-1:0] data_bit,
  input  qdf_pkg::phase_t               last_phase,
  output qdf_pkg::phase_t               phase,
  output qdf_pkg::qdf_evt_t             evt
);
  import qdf_pkg::*;

  logic cw;
  logic acw;

  assign phase = {port_value[data_bit], port_value[clock_bit]};

  // x2 decode: only clock edges count, data level gives the sense
  assign cw  = (last_phase == 2'd0 && phase == 2'd1) || (last_phase == 2'd3 && phase == 2'd2);
  assign acw = (last_phase == 2'd1 && phase == 2'd0) || (last_phase == 2'd2 && phase == 2'd3);

  assign evt.valid = cw | acw;
  assign evt.acw   = acw;

endmodule

// ===== design/qdf_fifo.sv =====
`timescale 1ns / 1ps
module qdf_fifo (
  input  logic                        clk,
  input  logic                        rst_n,
  input  qdf_pkg::qdf_fifo_req_t      req,
  output logic                        pop_acw,
  output logic [qdf_pkg::CNT_W-1:0]   count,
  output logic [qdf_pkg::CNT_W-1:0]   count_nxt
);
  import qdf_pkg::*;

  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(FIFO_DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(FIFO_DEPTH);

  logic              event_store_r [FIFO_DEPTH];
  logic [PTR_W-1:0]  head_r, head_nxt;
  logic [PTR_W-1:0]  tail_r, tail_nxt;
  logic [CNT_W-1:0]  count_r;
  logic              do_push;
  logic              do_pop;

  assign do_push = req.push && (count_r != CNT_FULL);   // full drops the event
  assign do_pop  = req.pop && (count_r != '0);

  assign pop_acw = event_store_r[head_r];
  assign count   = count_r;

  always_comb begin
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    count_nxt = count_r;
    if (do_push) begin
      tail_nxt  = (tail_r == PTR_LAST) ? '0 : tail_r + 1'b1;
      count_nxt = count_r + 1'b1;
    end
    if (do_pop) begin
      head_nxt  = (head_r == PTR_LAST) ? '0 : head_r + 1'b1;
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
    end else begin
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      event_store_r[tail_r] <= req.push_acw;
    end
  end

endmodule

// ===== design/quadrature_direction_fifo_core.sv =====
`timescale 1ns / 1ps
// Quadrature x2 direction decoder with a 16-entry direction event queue.
// Each item passes through the input register and then the result register; a stalled
// output holds it in the input register.
// Throughput: one item per cycle while out_chan.ready lets the result register advance;
// the phase compare and queue update between the two registers are combinational.
// Reset (rst_n, synchronous): queue empty, stored phase 0, clock_bit 0, data_bit 1, enable 1.
module quadrature_direction_fifo_core (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [qdf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [qdf_pkg::CFG_DATA_W-1:0] cfg_data,
  qdf_in_if.sink                         in_chan,
  qdf_out_if.source                      out_chan
);
  import qdf_pkg::*;

  logic [BIT_SEL_W-1:0] clock_bit_r;
  logic [BIT_SEL_W-1:0] data_bit_r;
  logic                 enable_r;

  logic                 s1_valid_r;
  logic                 s1_op_r;
  logic [PORT_W-1:0]    s1_port_r;

  logic                 out_valid_r;
  dir_t                 out_dir_r, out_dir_nxt;
  logic [CNT_W-1:0]     out_pending_r;

  phase_t               last_phase_r;
  phase_t               phase;
  qdf_evt_t             evt;
  qdf_fifo_req_t        fifo_req;
  logic                 pop_acw;
  logic [CNT_W-1:0]     count;
  logic [CNT_W-1:0]     count_nxt;

  logic                 advance;
  logic                 fire;
  logic                 sample_en;

  assign advance = !out_valid_r || out_chan.ready;
  assign fire    = s1_valid_r && advance;
  assign in_chan.ready = !s1_valid_r || advance;

  assign out_chan.valid     = out_valid_r;
  assign out_chan.direction = out_dir_r;
  assign out_chan.pending   = out_pending_r;

  qdf_decode u_decode (
    .port_value (s1_port_r),
    .clock_bit  (clock_bit_r),
    .data_bit   (data_bit_r),
    .last_phase (last_phase_r),
    .phase      (phase),
    .evt        (evt)
  );

  assign sample_en = fire && (s1_op_r == OP_SAMPLE) && enable_r;

  always_comb begin
    fifo_req.push     = sample_en && evt.valid;
    fifo_req.push_acw = evt.acw ? EVT_ACW : EVT_CW;
    fifo_req.pop      = fire && (s1_op_r == OP_READ);
  end

  qdf_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .req       (fifo_req),
    .pop_acw   (pop_acw),
    .count     (count),
    .count_nxt (count_nxt)
  );

  always_comb begin
    out_dir_nxt = DIR_NONE;
    if (s1_op_r == OP_READ && count != '0) begin
      out_dir_nxt = (pop_acw == EVT_ACW) ? DIR_ACW : DIR_CW;
    end
  end

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clock_bit_r <= BIT_SEL_W'(0);
      data_bit_r  <= BIT_SEL_W'(1);
      enable_r    <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_CLOCK_BIT: clock_bit_r <= cfg_data;
        CFG_DATA_BIT:  data_bit_r  <= cfg_data;
        CFG_ENABLE:    enable_r    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
      last_phase_r <= '0;
    end else begin
      if (in_chan.ready) begin
        s1_valid_r <= in_chan.valid;
      end
      if (fire) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
      if (sample_en) begin
        last_phase_r <= phase;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (in_chan.ready && in_chan.valid) begin
      s1_op_r   <= in_chan.operation;
      s1_port_r <= in_chan.port_value;
    end
    if (fire) begin
      out_dir_r     <= out_dir_nxt;
      out_pending_r <= count_nxt;
    end
  end

endmodule
